// ----- sv/cpt_pkg.sv -----
// Shared types and region codes for the closest point on triangle block.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

    typedef logic [2:0] t_region;

    localparam t_region RGN_A  = 3'd0;
    localparam t_region RGN_B  = 3'd1;
    localparam t_region RGN_AB = 3'd2;
    localparam t_region RGN_C  = 3'd3;
    localparam t_region RGN_AC = 3'd4;
    localparam t_region RGN_BC = 3'd5;
    localparam t_region RGN_IN = 3'd6;

endpackage
`default_nettype wire

// ----- sv/closest_point_on_triangle.sv -----
// Top level: pipelined closest point on a triangle with Voronoi region code.
//
// Usage: present corners a, b, c and a query point, all signed fixed point, and
// raise start. An item is taken at every clock edge with start high; busy is
// always low, so one item enters every cycle.
// Each item gives exactly one result: o_near_x/y/z and o_region appear for one
// cycle with o_done high. Results leave in the order items came in.
// Throughput is one item per cycle. The pipeline runs through the exact dot
// and cross products (two chunked multiplier passes of two stages each) and
// the rounding divider, which resolves one quotient bit per stage.
// The receiver cannot stall; results must be taken as they appear.
// Reset clears all valid bits, so no result appears until items are taken.
// Items are independent; no state is kept between them.
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_triangle #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_a_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_b_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_c_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_query_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_query_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_query_z,
    output logic                               o_done,
    output logic signed [COORD_WIDTH-1:0]      o_near_x,
    output logic signed [COORD_WIDTH-1:0]      o_near_y,
    output logic signed [COORD_WIDTH-1:0]      o_near_z,
    output cpt_pkg::t_region                   o_region
);
    import cpt_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int DIFF_W  = CW + 1;
    localparam int DOT_W   = 2 * DIFF_W + 2;
    localparam int CROSS_W = 2 * DOT_W + 1;
    localparam int DEN_W   = CROSS_W + 2;
    localparam int NUM_W   = DIFF_W + CROSS_W + 1;
    localparam int GEO_W   = 9 * CW + 9 * DIFF_W;
    localparam int CHUNK_W = 18;
    localparam int DIV_LAT = CW + 4;

    logic signed [CW-1:0]     w_a [3];
    logic signed [CW-1:0]     w_b [3];
    logic signed [CW-1:0]     w_c [3];
    logic signed [CW-1:0]     w_p [3];
    logic signed [DIFF_W-1:0] w_ab [3];
    logic signed [DIFF_W-1:0] w_ac [3];
    logic signed [DIFF_W-1:0] w_bc [3];
    logic [GEO_W-1:0]         w_geo;

    // Stage 1: edge and query vectors.
    logic signed [DIFF_W-1:0] r1_ab [3];
    logic signed [DIFF_W-1:0] r1_ac [3];
    logic signed [DIFF_W-1:0] r1_ap [3];
    logic signed [DIFF_W-1:0] r1_bp [3];
    logic signed [DIFF_W-1:0] r1_cp [3];
    logic [GEO_W-1:0]         r1_geo;
    logic                     r_v1;

    // Stage 2: per-axis products; stage 3: the six dot products.
    logic signed [2*DIFF_W-1:0] r2_pr [6][3];
    logic [GEO_W-1:0]           r2_geo;
    logic                       r_v2;
    logic signed [DOT_W-1:0]    r3_e [6];
    logic [GEO_W-1:0]           r3_geo;
    logic                       r_v3;

    // Stages 4 and 5: cross terms in the multipliers.
    logic signed [DOT_W-1:0]   r4_e [6];
    logic signed [DOT_W-1:0]   r5_e [6];
    logic [GEO_W-1:0]          r4_geo;
    logic [GEO_W-1:0]          r5_geo;
    logic signed [2*DOT_W-1:0] w_xp [6];
    logic                      w_v5;

    // Stage 6: barycentric numerators and region decision.
    logic signed [CROSS_W-1:0] w_ua;
    logic signed [CROSS_W-1:0] w_ub;
    logic signed [CROSS_W-1:0] w_uc;
    t_region                   n_rg;
    logic signed [CROSS_W-1:0] r6_ua;
    logic signed [CROSS_W-1:0] r6_ub;
    logic signed [CROSS_W-1:0] r6_uc;
    logic signed [DOT_W-1:0]   r6_e [6];
    logic [GEO_W-1:0]          r6_geo;
    t_region                   r6_rg;
    logic                      r_v6;

    // Stage 7: operands of the placement for each axis.
    logic signed [CW-1:0]      g_a [3];
    logic signed [CW-1:0]      g_b [3];
    logic signed [CW-1:0]      g_c [3];
    logic signed [DIFF_W-1:0]  g_ab [3];
    logic signed [DIFF_W-1:0]  g_ac [3];
    logic signed [DIFF_W-1:0]  g_bc [3];
    logic signed [DIFF_W-1:0]  n_x [3];
    logic signed [DIFF_W-1:0]  n_y [3];
    logic signed [CW-1:0]      n_base [3];
    logic signed [CROSS_W-1:0] n_u;
    logic signed [CROSS_W-1:0] n_v;
    logic signed [DEN_W-1:0]   n_den;
    logic signed [DIFF_W-1:0]  r7_x [3];
    logic signed [DIFF_W-1:0]  r7_y [3];
    logic signed [CW-1:0]      r7_base [3];
    logic signed [CROSS_W-1:0] r7_u;
    logic signed [CROSS_W-1:0] r7_v;
    logic signed [DEN_W-1:0]   r7_den;
    t_region                   r7_rg;
    logic                      r_v7;

    // Stages 8 and 9: numerator products; stage 10: numerator sum.
    logic signed [DIFF_W+CROSS_W-1:0] w_pxu [3];
    logic signed [DIFF_W+CROSS_W-1:0] w_pyv [3];
    logic                             w_v9;
    logic signed [DEN_W-1:0]          r8_den;
    logic signed [DEN_W-1:0]          r9_den;
    logic signed [CW-1:0]             r8_base [3];
    logic signed [CW-1:0]             r9_base [3];
    t_region                          r8_rg;
    t_region                          r9_rg;
    logic signed [NUM_W-1:0]          r10_num [3];
    logic signed [DEN_W-1:0]          r10_den;
    logic signed [CW-1:0]             r10_base [3];
    t_region                          r10_rg;
    logic                             r_v10;

    logic signed [CW-1:0] w_near [3];
    t_region              r_rgd [DIV_LAT];

    assign busy = 1'b0;

    assign w_a[0] = i_a_x;
    assign w_a[1] = i_a_y;
    assign w_a[2] = i_a_z;
    assign w_b[0] = i_b_x;
    assign w_b[1] = i_b_y;
    assign w_b[2] = i_b_z;
    assign w_c[0] = i_c_x;
    assign w_c[1] = i_c_y;
    assign w_c[2] = i_c_z;
    assign w_p[0] = i_query_x;
    assign w_p[1] = i_query_y;
    assign w_p[2] = i_query_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_ab[k] = DIFF_W'(w_b[k]) - DIFF_W'(w_a[k]);
            w_ac[k] = DIFF_W'(w_c[k]) - DIFF_W'(w_a[k]);
            w_bc[k] = DIFF_W'(w_c[k]) - DIFF_W'(w_b[k]);
            w_geo[k*CW +: CW]                     = w_a[k];
            w_geo[3*CW + k*CW +: CW]              = w_b[k];
            w_geo[6*CW + k*CW +: CW]              = w_c[k];
            w_geo[9*CW + k*DIFF_W +: DIFF_W]      = w_ab[k];
            w_geo[9*CW + (3+k)*DIFF_W +: DIFF_W]  = w_ac[k];
            w_geo[9*CW + (6+k)*DIFF_W +: DIFF_W]  = w_bc[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r1_ab[k] <= w_ab[k];
            r1_ac[k] <= w_ac[k];
            r1_ap[k] <= DIFF_W'(w_p[k]) - DIFF_W'(w_a[k]);
            r1_bp[k] <= DIFF_W'(w_p[k]) - DIFF_W'(w_b[k]);
            r1_cp[k] <= DIFF_W'(w_p[k]) - DIFF_W'(w_c[k]);
        end
        r1_geo <= w_geo;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r2_pr[0][k] <= r1_ab[k] * r1_ap[k];
            r2_pr[1][k] <= r1_ac[k] * r1_ap[k];
            r2_pr[2][k] <= r1_ab[k] * r1_bp[k];
            r2_pr[3][k] <= r1_ac[k] * r1_bp[k];
            r2_pr[4][k] <= r1_ab[k] * r1_cp[k];
            r2_pr[5][k] <= r1_ac[k] * r1_cp[k];
        end
        r2_geo <= r1_geo;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r3_e[i] <= DOT_W'(r2_pr[i][0]) + DOT_W'(r2_pr[i][1]) + DOT_W'(r2_pr[i][2]);
        end
        r3_geo <= r2_geo;
    end

    // Cross terms: e1*e4, e3*e2, e5*e2, e1*e6, e3*e6, e5*e4.
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W), .CHUNK_W(CHUNK_W)) u_x14 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3),
        .i_a(r3_e[0]), .i_b(r3_e[3]), .o_vld(w_v5), .o_p(w_xp[0])
    );
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W), .CHUNK_W(CHUNK_W)) u_x32 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3),
        .i_a(r3_e[2]), .i_b(r3_e[1]), .o_vld(), .o_p(w_xp[1])
    );
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W), .CHUNK_W(CHUNK_W)) u_x52 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3),
        .i_a(r3_e[4]), .i_b(r3_e[1]), .o_vld(), .o_p(w_xp[2])
    );
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W), .CHUNK_W(CHUNK_W)) u_x16 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3),
        .i_a(r3_e[0]), .i_b(r3_e[5]), .o_vld(), .o_p(w_xp[3])
    );
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W), .CHUNK_W(CHUNK_W)) u_x36 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3),
        .i_a(r3_e[2]), .i_b(r3_e[5]), .o_vld(), .o_p(w_xp[4])
    );
    cpt_mul #(.A_W(DOT_W), .B_W(DOT_W), .CHUNK_W(CHUNK_W)) u_x54 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v3),
        .i_a(r3_e[4]), .i_b(r3_e[3]), .o_vld(), .o_p(w_xp[5])
    );

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r4_e[i] <= r3_e[i];
            r5_e[i] <= r4_e[i];
        end
        r4_geo <= r3_geo;
        r5_geo <= r4_geo;
    end

    // Region tests in the order of the classic scheme; the first that holds wins.
    always_comb begin
        w_uc = CROSS_W'(w_xp[0]) - CROSS_W'(w_xp[1]);
        w_ub = CROSS_W'(w_xp[2]) - CROSS_W'(w_xp[3]);
        w_ua = CROSS_W'(w_xp[4]) - CROSS_W'(w_xp[5]);
        priority if (r5_e[0] <= 0 && r5_e[1] <= 0) begin
            n_rg = RGN_A;
        end else if (r5_e[2] >= 0 && r5_e[3] <= r5_e[2]) begin
            n_rg = RGN_B;
        end else if (w_uc <= 0 && r5_e[0] >= 0 && r5_e[2] <= 0) begin
            n_rg = RGN_AB;
        end else if (r5_e[5] >= 0 && r5_e[4] <= r5_e[5]) begin
            n_rg = RGN_C;
        end else if (w_ub <= 0 && r5_e[1] >= 0 && r5_e[5] <= 0) begin
            n_rg = RGN_AC;
        end else if (w_ua <= 0 && r5_e[3] >= r5_e[2] && r5_e[4] >= r5_e[5]) begin
            n_rg = RGN_BC;
        end else begin
            n_rg = RGN_IN;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_ua  <= w_ua;
        r6_ub  <= w_ub;
        r6_uc  <= w_uc;
        r6_rg  <= n_rg;
        r6_geo <= r5_geo;
        for (int i = 0; i < 6; i++) begin
            r6_e[i] <= r5_e[i];
        end
    end

    // Every region is expressed as base + (x*u + y*v) / den; corners use den 0.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            g_a[k]  = $signed(r6_geo[k*CW +: CW]);
            g_b[k]  = $signed(r6_geo[3*CW + k*CW +: CW]);
            g_c[k]  = $signed(r6_geo[6*CW + k*CW +: CW]);
            g_ab[k] = $signed(r6_geo[9*CW + k*DIFF_W +: DIFF_W]);
            g_ac[k] = $signed(r6_geo[9*CW + (3+k)*DIFF_W +: DIFF_W]);
            g_bc[k] = $signed(r6_geo[9*CW + (6+k)*DIFF_W +: DIFF_W]);
            n_x[k]    = '0;
            n_y[k]    = '0;
            n_base[k] = g_a[k];
        end
        n_u   = '0;
        n_v   = '0;
        n_den = '0;
        unique case (r6_rg)
            RGN_A: begin
            end
            RGN_B: begin
                for (int k = 0; k < 3; k++) n_base[k] = g_b[k];
            end
            RGN_C: begin
                for (int k = 0; k < 3; k++) n_base[k] = g_c[k];
            end
            RGN_AB: begin
                for (int k = 0; k < 3; k++) n_x[k] = g_ab[k];
                n_u   = CROSS_W'(r6_e[0]);
                n_den = DEN_W'(r6_e[0]) - DEN_W'(r6_e[2]);
            end
            RGN_AC: begin
                for (int k = 0; k < 3; k++) n_x[k] = g_ac[k];
                n_u   = CROSS_W'(r6_e[1]);
                n_den = DEN_W'(r6_e[1]) - DEN_W'(r6_e[5]);
            end
            RGN_BC: begin
                for (int k = 0; k < 3; k++) begin
                    n_x[k]    = g_bc[k];
                    n_base[k] = g_b[k];
                end
                n_u   = CROSS_W'(r6_e[3]) - CROSS_W'(r6_e[2]);
                n_den = DEN_W'(r6_e[3]) - DEN_W'(r6_e[2])
                      + DEN_W'(r6_e[4]) - DEN_W'(r6_e[5]);
            end
            RGN_IN: begin
                for (int k = 0; k < 3; k++) begin
                    n_x[k] = g_ab[k];
                    n_y[k] = g_ac[k];
                end
                n_u   = r6_ub;
                n_v   = r6_uc;
                n_den = DEN_W'(r6_ua) + DEN_W'(r6_ub) + DEN_W'(r6_uc);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r7_x[k]    <= n_x[k];
            r7_y[k]    <= n_y[k];
            r7_base[k] <= n_base[k];
        end
        r7_u   <= n_u;
        r7_v   <= n_v;
        r7_den <= n_den;
        r7_rg  <= r6_rg;
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        if (k == 0) begin : g_first
            cpt_mul #(.A_W(DIFF_W), .B_W(CROSS_W), .CHUNK_W(CHUNK_W)) u_mxu (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v7),
                .i_a(r7_x[k]), .i_b(r7_u), .o_vld(w_v9), .o_p(w_pxu[k])
            );
        end else begin : g_rest
            cpt_mul #(.A_W(DIFF_W), .B_W(CROSS_W), .CHUNK_W(CHUNK_W)) u_mxu (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v7),
                .i_a(r7_x[k]), .i_b(r7_u), .o_vld(), .o_p(w_pxu[k])
            );
        end
        cpt_mul #(.A_W(DIFF_W), .B_W(CROSS_W), .CHUNK_W(CHUNK_W)) u_myv (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v7),
            .i_a(r7_y[k]), .i_b(r7_v), .o_vld(), .o_p(w_pyv[k])
        );
        cpt_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .OUT_W(CW)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(r_v10),
            .i_num(r10_num[k]), .i_den(r10_den), .i_base(r10_base[k]),
            .o_vld(), .o_val(w_near[k])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r8_base[k]  <= r7_base[k];
            r9_base[k]  <= r8_base[k];
            r10_base[k] <= r9_base[k];
            r10_num[k]  <= NUM_W'(w_pxu[k]) + NUM_W'(w_pyv[k]);
        end
        r8_den  <= r7_den;
        r9_den  <= r8_den;
        r10_den <= r9_den;
        r8_rg   <= r7_rg;
        r9_rg   <= r8_rg;
        r10_rg  <= r9_rg;
    end

    // The region code rides alongside the dividers.
    always_ff @(posedge i_clk) begin
        r_rgd[0] <= r10_rg;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_rgd[i] <= r_rgd[i-1];
        end
    end

    // The dividers hold the same valid pipeline; this chain tracks it at the top.
    logic r_vd [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
            r_v10 <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) r_vd[i] <= 1'b0;
        end else begin
            r_v1  <= start;
            r_v2  <= r_v1;
            r_v3  <= r_v2;
            r_v6  <= w_v5;
            r_v7  <= r_v6;
            r_v10 <= w_v9;
            r_vd[0] <= r_v10;
            for (int i = 1; i < DIV_LAT; i++) r_vd[i] <= r_vd[i-1];
        end
    end

    assign o_done   = r_vd[DIV_LAT-1];
    assign o_near_x = w_near[0];
    assign o_near_y = w_near[1];
    assign o_near_z = w_near[2];
    assign o_region = r_rgd[DIV_LAT-1];

endmodule
`default_nettype wire

// ----- sv/cpt_mul.sv -----
// Two-stage signed multiplier that splits the second operand into chunks.
`timescale 1ns / 1ps
`default_nettype none
module cpt_mul #(
    parameter int A_W     = 36,
    parameter int B_W     = 36,
    parameter int CHUNK_W = 18
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_vld,
    input  wire logic signed [A_W-1:0]       i_a,
    input  wire logic signed [B_W-1:0]       i_b,
    output logic                             o_vld,
    output logic signed [A_W+B_W-1:0]        o_p
);
    localparam int NCH   = (B_W + CHUNK_W - 1) / CHUNK_W;
    localparam int EXT_W = NCH * CHUNK_W;
    localparam int PP_W  = A_W + CHUNK_W + 1;
    localparam int SUM_W = A_W + EXT_W;

    logic signed [EXT_W-1:0]   w_b;
    logic signed [PP_W-1:0]    r_pp [NCH];
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [A_W+B_W-1:0] r_p;
    logic                      r_v1;
    logic                      r_v2;

    assign w_b = EXT_W'(i_b);

    // Lower chunks are unsigned digits; only the top chunk carries the sign.
    for (genvar j = 0; j < NCH; j++) begin : g_pp
        logic signed [CHUNK_W:0] w_ch;
        if (j == NCH - 1) begin : g_top
            assign w_ch = {w_b[EXT_W-1], w_b[j*CHUNK_W +: CHUNK_W]};
        end else begin : g_low
            assign w_ch = {1'b0, w_b[j*CHUNK_W +: CHUNK_W]};
        end
        always_ff @(posedge i_clk) begin
            r_pp[j] <= i_a * w_ch;
        end
    end

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < NCH; j++) begin
            w_sum = w_sum + (SUM_W'(r_pp[j]) <<< (j * CHUNK_W));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_sum[A_W+B_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    assign o_vld = r_v2;
    assign o_p   = r_p;

endmodule
`default_nettype wire

// ----- sv/cpt_div.sv -----
// Pipelined rounding divider that adds the quotient to a base and saturates.
`timescale 1ns / 1ps
`default_nettype none
module cpt_div #(
    parameter int NUM_W = 91,
    parameter int DEN_W = 75,
    parameter int OUT_W = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_vld,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic signed [DEN_W-1:0] i_den,
    input  wire logic signed [OUT_W-1:0] i_base,
    output logic                         o_vld,
    output logic signed [OUT_W-1:0]      o_val
);
    // A quotient of 2**OUT_W or more always saturates, so only OUT_W bits are formed.
    localparam int QUO_W = OUT_W;
    localparam int REM_W = DEN_W + QUO_W;
    localparam int CMP_W = ((NUM_W > REM_W) ? NUM_W : REM_W) + 1;
    localparam int SUM_W = QUO_W + 3;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((longint'(1) << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    // Magnitude stage.
    logic [NUM_W-1:0]        r_nu;
    logic [DEN_W-1:0]        r_du;
    logic                    r_an;
    logic                    r_az;
    logic signed [OUT_W-1:0] r_ab;
    logic                    r_av;

    // Division stages; index 0 is the range check stage.
    logic [REM_W-1:0]        r_rem  [QUO_W+1];
    logic [QUO_W-1:0]        r_q    [QUO_W+1];
    logic [DEN_W-1:0]        r_d    [QUO_W+1];
    logic                    r_neg  [QUO_W+1];
    logic                    r_dz   [QUO_W+1];
    logic                    r_ovf  [QUO_W+1];
    logic signed [OUT_W-1:0] r_base [QUO_W+1];
    logic                    r_v    [QUO_W+1];

    // Rounding stage.
    logic [QUO_W:0]          r_qr;
    logic                    r_rn;
    logic                    r_rz;
    logic                    r_ro;
    logic signed [OUT_W-1:0] r_rb;
    logic                    r_rv;

    logic signed [SUM_W-1:0] w_mag;
    logic signed [SUM_W-1:0] w_bas;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [OUT_W-1:0] n_val;
    logic signed [OUT_W-1:0] r_val;
    logic                    r_ov;

    always_ff @(posedge i_clk) begin
        r_nu <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        r_du <= i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        r_an <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        r_az <= (i_den == '0);
        r_ab <= i_base;
    end

    always_ff @(posedge i_clk) begin
        r_ovf[0]  <= (CMP_W'(r_nu) >= (CMP_W'(r_du) << QUO_W));
        r_rem[0]  <= REM_W'(r_nu);
        r_q[0]    <= '0;
        r_d[0]    <= r_du;
        r_neg[0]  <= r_an;
        r_dz[0]   <= r_az;
        r_base[0] <= r_ab;
    end

    // One restoring step per stage, most significant quotient bit first.
    for (genvar i = 0; i < QUO_W; i++) begin : g_step
        localparam int BIT = QUO_W - 1 - i;
        logic [REM_W:0] w_t;
        assign w_t = {1'b0, r_rem[i]} - ((REM_W + 1)'(r_d[i]) << BIT);
        always_ff @(posedge i_clk) begin
            r_rem[i+1]  <= w_t[REM_W] ? r_rem[i] : w_t[REM_W-1:0];
            r_q[i+1]    <= r_q[i] | (QUO_W'(!w_t[REM_W]) << BIT);
            r_d[i+1]    <= r_d[i];
            r_neg[i+1]  <= r_neg[i];
            r_dz[i+1]   <= r_dz[i];
            r_ovf[i+1]  <= r_ovf[i];
            r_base[i+1] <= r_base[i];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    // Round half away from zero on the magnitude.
    always_ff @(posedge i_clk) begin
        r_qr <= (QUO_W + 1)'(r_q[QUO_W])
              + (QUO_W + 1)'({r_rem[QUO_W], 1'b0} >= (REM_W + 1)'(r_d[QUO_W]));
        r_rn <= r_neg[QUO_W];
        r_rz <= r_dz[QUO_W];
        r_ro <= r_ovf[QUO_W];
        r_rb <= r_base[QUO_W];
    end

    always_comb begin
        w_mag = $signed(SUM_W'(r_qr));
        w_bas = SUM_W'(r_rb);
        w_sum = r_rn ? (w_bas - w_mag) : (w_bas + w_mag);
        priority if (r_rz) begin
            n_val = r_rb;
        end else if (r_ro) begin
            n_val = r_rn ? SAT_LO[OUT_W-1:0] : SAT_HI[OUT_W-1:0];
        end else if (w_sum > SAT_HI) begin
            n_val = SAT_HI[OUT_W-1:0];
        end else if (w_sum < SAT_LO) begin
            n_val = SAT_LO[OUT_W-1:0];
        end else begin
            n_val = w_sum[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_v[0] <= 1'b0;
            r_rv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_av <= i_vld;
            r_v[0] <= r_av;
            r_rv <= r_v[QUO_W];
            r_ov <= r_rv;
        end
    end

    assign o_vld = r_ov;
    assign o_val = r_val;

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the closest point on triangle block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import cpt_pkg::*;

    localparam int W = 16;
    localparam int N_RANDOM = 1500;
    localparam int N_CALM = 200;
    localparam int DRAIN_CYCLES = 60;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [W-1:0] t_coord;

    // Corners a, b, c and the query point, x y z each.
    typedef struct {
        t_coord v[12];
    } t_tri_query;

    typedef struct {
        t_coord nx;
        t_coord ny;
        t_coord nz;
        t_region rgn;
    } t_nearest;

    class nearest_point_board;
        t_nearest pending[$];
        int mismatches = 0;

        task report(string msg);
            $display("%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function automatic t_wide dot(t_wide x[3], t_wide y[3]);
            return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
        endfunction

        // Quotient rounded to nearest, ties away from zero.
        function automatic t_wide div_round(t_wide n, t_wide d);
            t_wide un, ud, q, r;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            q = un / ud;
            r = un % ud;
            if (2 * r >= ud) q = q + 1;
            return ((n < 0) != (d < 0)) ? -q : q;
        endfunction

        function automatic t_coord place(t_wide base, t_wide num, t_wide den);
            t_wide v;
            v = base;
            if (den != 0) v = v + div_round(num, den);
            if (v > 32767) v = t_wide'(32767);
            if (v < -32768) v = t_wide'(-32768);
            return t_coord'(v);
        endfunction

        function automatic void note(t_tri_query g);
            t_wide a[3], b[3], c[3], p[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
            t_wide e1, e2, e3, e4, e5, e6, ua, ub, uc, den, n;
            t_wide zero;
            t_coord o[3];
            t_nearest r;
            zero = '0;
            for (int k = 0; k < 3; k++) begin
                a[k] = t_wide'(g.v[k]);
                b[k] = t_wide'(g.v[3 + k]);
                c[k] = t_wide'(g.v[6 + k]);
                p[k] = t_wide'(g.v[9 + k]);
                ab[k] = b[k] - a[k];
                ac[k] = c[k] - a[k];
                ap[k] = p[k] - a[k];
                bp[k] = p[k] - b[k];
                cp[k] = p[k] - c[k];
                bc[k] = c[k] - b[k];
            end
            e1 = dot(ab, ap);
            e2 = dot(ac, ap);
            e3 = dot(ab, bp);
            e4 = dot(ac, bp);
            e5 = dot(ab, cp);
            e6 = dot(ac, cp);
            uc = e1 * e4 - e3 * e2;
            ub = e5 * e2 - e1 * e6;
            ua = e3 * e6 - e5 * e4;
            if (e1 <= 0 && e2 <= 0) begin
                for (int k = 0; k < 3; k++) o[k] = place(a[k], zero, zero);
                r.rgn = RGN_A;
            end else if (e3 >= 0 && e4 <= e3) begin
                for (int k = 0; k < 3; k++) o[k] = place(b[k], zero, zero);
                r.rgn = RGN_B;
            end else if (uc <= 0 && e1 >= 0 && e3 <= 0) begin
                for (int k = 0; k < 3; k++) o[k] = place(a[k], ab[k] * e1, e1 - e3);
                r.rgn = RGN_AB;
            end else if (e6 >= 0 && e5 <= e6) begin
                for (int k = 0; k < 3; k++) o[k] = place(c[k], zero, zero);
                r.rgn = RGN_C;
            end else if (ub <= 0 && e2 >= 0 && e6 <= 0) begin
                for (int k = 0; k < 3; k++) o[k] = place(a[k], ac[k] * e2, e2 - e6);
                r.rgn = RGN_AC;
            end else if (ua <= 0 && e4 >= e3 && e5 >= e6) begin
                n = e4 - e3;
                for (int k = 0; k < 3; k++)
                    o[k] = place(b[k], bc[k] * n, n + (e5 - e6));
                r.rgn = RGN_BC;
            end else begin
                den = ua + ub + uc;
                for (int k = 0; k < 3; k++)
                    o[k] = place(a[k], ab[k] * ub + ac[k] * uc, den);
                r.rgn = RGN_IN;
            end
            r.nx = o[0];
            r.ny = o[1];
            r.nz = o[2];
            pending = {pending, r};
        endfunction

        task check(t_nearest got);
            t_nearest want;
            if (pending.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            want = pending.pop_front();
            if (got.nx !== want.nx) report($sformatf("near_x %0d, want %0d", got.nx, want.nx));
            if (got.ny !== want.ny) report($sformatf("near_y %0d, want %0d", got.ny, want.ny));
            if (got.nz !== want.nz) report($sformatf("near_z %0d, want %0d", got.nz, want.nz));
            if (got.rgn !== want.rgn)
                report($sformatf("region %0d, want %0d", got.rgn, want.rgn));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_coord coord_in[12];
    logic o_done;
    t_coord o_near_x, o_near_y, o_near_z;
    t_region o_region;
    nearest_point_board board = new();

    always #5 i_clk = ~i_clk;

    closest_point_on_triangle #(.COORD_WIDTH(W)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_x(coord_in[0]), .i_a_y(coord_in[1]), .i_a_z(coord_in[2]),
        .i_b_x(coord_in[3]), .i_b_y(coord_in[4]), .i_b_z(coord_in[5]),
        .i_c_x(coord_in[6]), .i_c_y(coord_in[7]), .i_c_z(coord_in[8]),
        .i_query_x(coord_in[9]), .i_query_y(coord_in[10]), .i_query_z(coord_in[11]),
        .o_done(o_done), .o_near_x(o_near_x), .o_near_y(o_near_y),
        .o_near_z(o_near_z), .o_region(o_region)
    );

    initial for (int k = 0; k < 12; k++) coord_in[k] = '0;

    always @(posedge i_clk) begin
        t_tri_query g;
        t_nearest got;
        if (i_rst_n && start && !busy) begin
            g.v = coord_in;
            board.note(g);
        end
        if (i_rst_n && o_done) begin
            got.nx = o_near_x;
            got.ny = o_near_y;
            got.nz = o_near_z;
            got.rgn = o_region;
            board.check(got);
        end
    end

    task automatic send(t_tri_query g, bit allow_gaps);
        int gap;
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        coord_in <= g.v;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_coord pick_coord(int unsigned kind, t_coord base);
        case (kind)
            0: return t_coord'($urandom);
            1: return t_coord'(base + $signed($urandom_range(0, 4096)) - 2048);
            default: begin
                case ($urandom_range(0, 3))
                    0: return t_coord'(-32768);
                    1: return t_coord'(32767);
                    2: return t_coord'(0);
                    default: return t_coord'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic t_tri_query random_item();
        t_tri_query g;
        int unsigned kind, shape;
        t_coord base;
        int s;
        kind = $urandom_range(0, 9);
        kind = (kind < 3) ? 0 : (kind < 8) ? 1 : 2;
        base = t_coord'($urandom);
        for (int k = 0; k < 12; k++) g.v[k] = pick_coord(kind, base);
        // Degenerate triangles: repeated corners or collinear corners.
        shape = $urandom_range(0, 7);
        s = $urandom_range(0, 4) - 2;
        for (int k = 0; k < 3; k++) begin
            case (shape)
                0: g.v[3 + k] = g.v[k];
                1: g.v[6 + k] = g.v[k];
                2: g.v[6 + k] = g.v[3 + k];
                3: g.v[6 + k] = t_coord'(g.v[k] + s * (g.v[3 + k] - g.v[k]));
                default: ;
            endcase
        end
        return g;
    endfunction

    function automatic t_tri_query fill(int va, int vb, int vc, int vq);
        t_tri_query g;
        for (int k = 0; k < 3; k++) begin
            g.v[k] = t_coord'(va);
            g.v[3 + k] = t_coord'(vb);
            g.v[6 + k] = t_coord'(vc);
            g.v[9 + k] = t_coord'(vq);
        end
        return g;
    endfunction

    function automatic t_tri_query flat(int ax, int ay, int bx, int by, int cx, int cy,
                                        int px, int py, int pz);
        t_tri_query g;
        g = fill(0, 0, 0, 0);
        g.v[0] = t_coord'(ax); g.v[1] = t_coord'(ay);
        g.v[3] = t_coord'(bx); g.v[4] = t_coord'(by);
        g.v[6] = t_coord'(cx); g.v[7] = t_coord'(cy);
        g.v[9] = t_coord'(px); g.v[10] = t_coord'(py); g.v[11] = t_coord'(pz);
        return g;
    endfunction

    initial begin
        t_tri_query directed[$];
        int waited;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed = {directed, fill(-32768, -32768, -32768, -32768)};
        directed = {directed, fill(32767, 32767, 32767, 32767)};
        directed = {directed, fill(-32768, 32767, 0, -32768)};
        directed = {directed, fill(-32768, 32767, 0, 32767)};
        directed = {directed, fill(0, 0, 0, 1000)};
        // One flat triangle with the query in each region.
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, -500, -500, 300)};
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, 5000, -100, 0)};
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, 2001, -900, 77)};
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, -100, 5000, 0)};
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, -900, 1999, -5)};
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, 3000, 3001, 9)};
        directed = {directed, flat(0, 0, 4096, 0, 0, 4096, 1000, 1001, -2000)};
        // Huge triangle at full-scale coordinates with the query in region BC.
        directed = {directed, flat(-32768, -32768, 32767, -32768, -32768, 32767,
                                   32767, 32767, 32767)};
        // Repeated corners give zero edge denominators.
        directed = {directed, flat(100, 100, 100, 100, 900, 50, -300, 120, 0)};
        directed = {directed, flat(100, 100, 900, 50, 900, 50, 1200, 300, 0)};
        // Collinear corners give a zero interior denominator.
        directed = {directed, flat(0, 0, 1000, 0, 2000, 0, 1500, 10, 0)};
        directed = {directed, flat(0, 0, 2000, 0, 1000, 0, 500, -3, 40)};
        // Small triangles of either sign with the query over the interior.
        directed = {directed, flat(0, 0, 3, 0, 0, 5, 1, 1, 1)};
        directed = {directed, flat(0, 0, -3, 0, 0, -5, -1, -1, -1)};
        foreach (directed[i]) send(directed[i], 1'b1);

        for (int i = 0; i < N_RANDOM; i++) send(random_item(), i < N_RANDOM - N_CALM);

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (board.pending.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
